### sv/assert_macros.svh
// Assertion macros used by the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PL_ASSERT(label, clk, rst_n, prop, msg)
`define PL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/plist_pkg.sv
package plist_pkg;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_DELETE     = 3'd1,
		OP_DELETE_END = 3'd2,
		OP_DISPLAY    = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// What a cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_EXT
	} cell_op_t;
endpackage

### sv/plist_if.sv
interface plist_req_if import plist_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, op, value, position, input ready);
	modport sink (input valid, op, value, position, output ready);
endinterface

interface plist_rsp_if import plist_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic signed [VALUE_W-1:0] item_value;
	logic [IDX_W-1:0]          item_index;
	logic [IDX_W-1:0]          list_length;
	logic                      last;

	modport source (output valid, status, item_value, item_index, list_length, last,
		input ready);
	modport sink (input valid, status, item_value, item_index, list_length, last,
		output ready);
endinterface

### sv/plist_cell.sv
module plist_cell import plist_pkg::*; (
	input  logic                      clk,
	input  cell_op_t                  op,
	input  logic signed [VALUE_W-1:0] left_val,
	input  logic signed [VALUE_W-1:0] right_val,
	input  logic signed [VALUE_W-1:0] ext_val,
	output logic signed [VALUE_W-1:0] val
);
	logic signed [VALUE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:  val_q <= val_q;
			CELL_LEFT:  val_q <= left_val;
			CELL_RIGHT: val_q <= right_val;
			CELL_EXT:   val_q <= ext_val;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;
endmodule

### sv/positional_list_insert_delete_top.sv
// Channel | Dir | Fields                                                  | Per request
// req     | in  | op, value, position                                     | one
// rsp     | out | status, item_value, item_index, list_length, last       | 1 to DEPTH
//
// For insert, delete, delete-end and clear the result is
// registered and shown the cycle after the request is taken.
// Display starts up in the cycle in which it is taken, then rotates the chain by one cell
// per cycle while the response is not stalled, one element at a time; no request is taken
// until its last result has been registered.
// Reset empties the list at once; cell contents are not cleared.
// A stalled response holds the chain and the request side.
module positional_list_insert_delete_top import plist_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	plist_req_if.sink  req,
	plist_rsp_if.source rsp
);
	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AT_W  = $clog2(DEPTH);

	typedef enum logic {S_IDLE, S_SHOW} state_t;
	typedef enum logic [1:0] {SH_NONE, SH_INSERT, SH_REMOVE, SH_ROTATE} shift_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          disp_idx_q;
	logic                      rsp_valid_q;
	status_t                   rsp_status_q;
	logic signed [VALUE_W-1:0] rsp_value_q;
	logic [IDX_W-1:0]          rsp_index_q;
	logic [IDX_W-1:0]          rsp_length_q;
	logic                      rsp_last_q;

	logic signed [VALUE_W-1:0] cell_val [DEPTH];
	cell_op_t                  cell_op [DEPTH];
	logic signed [VALUE_W-1:0] ext_val;

	logic                      slot_free;
	logic                      req_fire;
	shift_t                    shift;
	logic [AT_W-1:0]           at;
	logic [POS_W-1:0]          pos_m1;
	logic [POS_W-1:0]          count_pos;
	logic                      res_valid;
	status_t                   res_status;
	logic signed [VALUE_W-1:0] res_value;
	logic [IDX_W-1:0]          res_index;
	logic [CNT_W-1:0]          res_count;
	logic                      res_last;
	logic                      go_show;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign req_fire  = req.valid && req.ready;
	assign pos_m1    = req.position - POS_W'(1);
	assign count_pos = POS_W'(count_q);

	always_comb begin
		shift      = SH_NONE;
		at         = '0;
		ext_val    = req.value;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_value  = '0;
		res_index  = '0;
		res_count  = count_q;
		res_last   = 1'b1;
		go_show    = 1'b0;
		if (state_q == S_SHOW) begin
			if (slot_free) begin
				shift     = SH_ROTATE;
				ext_val   = cell_val[0];
				res_valid = 1'b1;
				res_value = cell_val[0];
				res_index = IDX_W'(disp_idx_q) + IDX_W'(1);
				res_last  = (disp_idx_q + CNT_W'(1)) == count_q;
			end
		end else if (req_fire) begin
			res_valid = 1'b1;
			unique case (req.op)
				OP_INSERT: begin
					if (count_q >= CNT_W'(DEPTH)) begin
						res_status = ST_FULL;
					end else begin
						if (req.position == POS_W'(1) || count_q == '0) begin
							at = '0;
						end else if (req.position == '0) begin
							at = AT_W'(1);
						end else if (pos_m1 < count_pos) begin
							at = AT_W'(pos_m1);
						end else begin
							at = AT_W'(count_q);
						end
						shift     = SH_INSERT;
						res_value = req.value;
						res_index = IDX_W'(at) + IDX_W'(1);
						res_count = count_q + CNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else if (req.position == '0 || req.position > count_pos) begin
						res_status = ST_BADPOS;
					end else begin
						at        = AT_W'(pos_m1);
						shift     = SH_REMOVE;
						res_value = cell_val[at];
						res_index = IDX_W'(req.position);
						res_count = count_q - CNT_W'(1);
					end
				end
				OP_DELETE_END: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						at        = AT_W'(count_q - CNT_W'(1));
						res_value = cell_val[at];
						res_index = IDX_W'(count_q);
						res_count = count_q - CNT_W'(1);
					end
				end
				OP_DISPLAY: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						res_valid = 1'b0;
						go_show   = 1'b1;
					end
				end
				OP_CLEAR: begin
					res_count = '0;
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			unique case (shift)
				SH_INSERT: begin
					if (AT_W'(i) > at) begin
						cell_op[i] = CELL_LEFT;
					end else if (AT_W'(i) == at) begin
						cell_op[i] = CELL_EXT;
					end else begin
						cell_op[i] = CELL_HOLD;
					end
				end
				SH_REMOVE: begin
					cell_op[i] = (AT_W'(i) >= at) ? CELL_RIGHT : CELL_HOLD;
				end
				SH_ROTATE: begin
					if (CNT_W'(i + 1) < count_q) begin
						cell_op[i] = CELL_RIGHT;
					end else if (CNT_W'(i + 1) == count_q) begin
						cell_op[i] = CELL_EXT;
					end else begin
						cell_op[i] = CELL_HOLD;
					end
				end
				default: cell_op[i] = CELL_HOLD;
			endcase
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_val;
		logic signed [VALUE_W-1:0] right_val;

		if (g == 0) begin : g_head
			assign left_val = ext_val;
		end else begin : g_body
			assign left_val = cell_val[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_val = ext_val;
		end else begin : g_inner
			assign right_val = cell_val[g+1];
		end

		plist_cell u_cell (
			.clk       (clk),
			.op        (cell_op[g]),
			.left_val  (left_val),
			.right_val (right_val),
			.ext_val   (ext_val),
			.val       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			disp_idx_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_value_q  <= '0;
			rsp_index_q  <= '0;
			rsp_length_q <= '0;
			rsp_last_q   <= 1'b0;
		end else begin
			if (res_valid) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= res_status;
				rsp_value_q  <= res_value;
				rsp_index_q  <= res_index;
				rsp_length_q <= IDX_W'(res_count);
				rsp_last_q   <= res_last;
				count_q      <= res_count;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go_show) begin
						state_q    <= S_SHOW;
						disp_idx_q <= '0;
					end
				end
				S_SHOW: begin
					if (res_valid) begin
						disp_idx_q <= disp_idx_q + CNT_W'(1);
						if (res_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.item_value  = rsp_value_q;
	assign rsp.item_index  = rsp_index_q;
	assign rsp.list_length = rsp_length_q;
	assign rsp.last        = rsp_last_q;

	`PL_ASSERT(a_count_max, clk, arst_n, count_q <= CNT_W'(DEPTH),
		"List length exceeds depth.")
	`PL_ASSERT_IMPL(a_show_blocks, clk, arst_n, state_q == S_SHOW, !req.ready,
		"Request taken during display.")
	`PL_ASSERT_IMPL(a_show_idx, clk, arst_n, state_q == S_SHOW, disp_idx_q < count_q,
		"Display index out of range.")
	`PL_ASSERT_NEXT(a_show_len, clk, arst_n, state_q == S_SHOW,
		count_q == $past(count_q), "Length changed during display.")
	`PL_ASSERT_NEXT(a_clear, clk, arst_n, req.valid && req.ready && req.op == OP_CLEAR,
		count_q == '0, "Clear left elements.")
endmodule

### bench/positional_list_insert_delete_top_test.sv
`timescale 1ns / 1ps

module positional_list_insert_delete_top_test;
	import plist_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int QUIET_LIMIT = 500;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] item_value;
		logic [IDX_W-1:0]          item_index;
		logic [IDX_W-1:0]          list_length;
		logic                      last;
	} list_result_t;

	typedef struct packed {
		logic         pinned;
		list_result_t result;
	} pinned_result_t;

	typedef struct {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		int                        repeats;
		bit                        pinned;
		list_result_t              result;
	} list_step_t;

	// Rows that pin a result give it by hand; the rest are checked against the list copy.
	list_step_t directed_steps [25] = '{
		'{OP_DELETE,     32'sd0,           8'd1,   1,  1'b1, '{ST_EMPTY,  32'sd0,           7'd0, 7'd0,  1'b1}},
		'{OP_DELETE_END, 32'sd0,           8'd0,   1,  1'b1, '{ST_EMPTY,  32'sd0,           7'd0, 7'd0,  1'b1}},
		'{OP_DISPLAY,    32'sd0,           8'd0,   1,  1'b1, '{ST_EMPTY,  32'sd0,           7'd0, 7'd0,  1'b1}},
		'{OP_INSERT,     32'sh8000_0000,   8'd0,   1,  1'b1, '{ST_OK,     32'sh8000_0000,   7'd1, 7'd1,  1'b1}},
		'{OP_INSERT,     32'sh7fff_ffff,   8'd255, 1,  1'b1, '{ST_OK,     32'sh7fff_ffff,   7'd2, 7'd2,  1'b1}},
		'{OP_INSERT,     32'sd5,           8'd0,   1,  1'b1, '{ST_OK,     32'sd5,           7'd2, 7'd3,  1'b1}},
		'{OP_INSERT,     32'sd7,           8'd1,   1,  1'b1, '{ST_OK,     32'sd7,           7'd1, 7'd4,  1'b1}},
		'{OP_INSERT,     -32'sd1,          8'd4,   1,  1'b1, '{ST_OK,     -32'sd1,          7'd4, 7'd5,  1'b1}},
		'{OP_DELETE,     32'sd0,           8'd0,   1,  1'b1, '{ST_BADPOS, 32'sd0,           7'd0, 7'd5,  1'b1}},
		'{OP_DELETE,     32'sd0,           8'd6,   1,  1'b1, '{ST_BADPOS, 32'sd0,           7'd0, 7'd5,  1'b1}},
		'{OP_DELETE,     32'sd0,           8'd255, 1,  1'b1, '{ST_BADPOS, 32'sd0,           7'd0, 7'd5,  1'b1}},
		'{OP_DISPLAY,    32'sd0,           8'd0,   1,  1'b0, '0},
		'{OP_DELETE,     32'sd0,           8'd1,   1,  1'b0, '0},
		'{OP_DELETE,     32'sd0,           8'd4,   1,  1'b0, '0},
		'{OP_DELETE_END, 32'sd0,           8'd0,   1,  1'b0, '0},
		'{OP_CLEAR,      32'sd0,           8'd0,   1,  1'b1, '{ST_OK,     32'sd0,           7'd0, 7'd0,  1'b1}},
		'{OP_DELETE_END, 32'sd0,           8'd0,   1,  1'b1, '{ST_EMPTY,  32'sd0,           7'd0, 7'd0,  1'b1}},
		'{OP_INSERT,     32'sd100,         8'd255, 16, 1'b0, '0},
		'{OP_INSERT,     32'sd1,           8'd1,   1,  1'b1, '{ST_FULL,   32'sd0,           7'd0, 7'd16, 1'b1}},
		'{OP_INSERT,     32'sd2,           8'd0,   1,  1'b1, '{ST_FULL,   32'sd0,           7'd0, 7'd16, 1'b1}},
		'{OP_DISPLAY,    32'sd0,           8'd0,   1,  1'b0, '0},
		'{OP_DELETE,     32'sd0,           8'd16,  1,  1'b0, '0},
		'{OP_DELETE,     32'sd0,           8'd16,  1,  1'b1, '{ST_BADPOS, 32'sd0,           7'd0, 7'd15, 1'b1}},
		'{OP_INSERT,     -32'sd5,          8'd0,   1,  1'b0, '0},
		'{OP_CLEAR,      32'sd0,           8'd0,   1,  1'b1, '{ST_OK,     32'sd0,           7'd0, 7'd0,  1'b1}}
	};

	logic clk;
	logic arst_n;

	plist_req_if req();
	plist_rsp_if rsp();

	logic signed [VALUE_W-1:0] cells [LIST_DEPTH];
	int unsigned               held;
	list_result_t              fresh_results [$];
	list_result_t              expected_q [$];
	pinned_result_t            pinned_q [$];
	int                        error_count;
	int                        quiet_cycles;
	bit                        calm;
	bit                        hold_off_req;
	int                        stall_left;

	positional_list_insert_delete_top #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void push_result(status_t status, logic signed [VALUE_W-1:0] value,
		int index, bit last);
		list_result_t r;
		r.status = status;
		r.item_value = value;
		r.item_index = IDX_W'(index);
		r.list_length = IDX_W'(held);
		r.last = last;
		fresh_results.push_back(r);
	endfunction

	function automatic void apply_list_op(op_t op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] position);
		int p;
		int at;
		logic signed [VALUE_W-1:0] taken;
		p = int'(position);
		fresh_results.delete();
		case (op)
			OP_INSERT: begin
				if (held >= LIST_DEPTH) begin
					push_result(ST_FULL, '0, 0, 1'b1);
				end else begin
					if (p == 1 || held == 0)
						at = 0;
					else if (p == 0)
						at = 1;
					else
						at = (p - 1 < int'(held)) ? p - 1 : int'(held);
					for (int i = int'(held); i > at; i--)
						cells[i] = cells[i-1];
					cells[at] = value;
					held++;
					push_result(ST_OK, value, at + 1, 1'b1);
				end
			end
			OP_DELETE, OP_DELETE_END: begin
				if (op == OP_DELETE_END)
					p = int'(held);
				if (held == 0) begin
					push_result(ST_EMPTY, '0, 0, 1'b1);
				end else if (p == 0 || p > int'(held)) begin
					push_result(ST_BADPOS, '0, 0, 1'b1);
				end else begin
					taken = cells[p-1];
					for (int i = p - 1; i + 1 < int'(held); i++)
						cells[i] = cells[i+1];
					held--;
					push_result(ST_OK, taken, p, 1'b1);
				end
			end
			OP_DISPLAY: begin
				if (held == 0)
					push_result(ST_EMPTY, '0, 0, 1'b1);
				else
					for (int i = 0; i < int'(held); i++)
						push_result(ST_OK, cells[i], i + 1, i + 1 == int'(held));
			end
			OP_CLEAR: begin
				held = 0;
				push_result(ST_OK, '0, 0, 1'b1);
			end
			default: push_result(ST_OK, '0, 0, 1'b1);
		endcase
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		pinned_result_t pin;
		if (arst_n) begin
			quiet_cycles++;
			if (rsp.valid && rsp.ready) begin
				quiet_cycles = 0;
				got = '{status_t'(rsp.status), rsp.item_value, rsp.item_index,
					rsp.list_length, rsp.last};
				if (expected_q.size() == 0) begin
					error_count++;
					$display("%0t: result expected none, actual status %0d value %0d index %0d",
						$time, got.status, got.item_value, got.item_index);
				end else begin
					want = expected_q.pop_front();
					check_field("status", want.status, got.status);
					check_field("item_value", want.item_value, got.item_value);
					check_field("item_index", want.item_index, got.item_index);
					check_field("list_length", want.list_length, got.list_length);
					check_field("last", want.last, got.last);
				end
			end
			if (req.valid && req.ready) begin
				quiet_cycles = 0;
				apply_list_op(op_t'(req.op), req.value, req.position);
				pin = pinned_q.pop_front();
				if (pin.pinned)
					expected_q.push_back(pin.result);
				else
					foreach (fresh_results[i])
						expected_q.push_back(fresh_results[i]);
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("positional_list_insert_delete_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		rsp.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					stall_left = 60;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 3);
				end
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic offer_request(op_t op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] position, bit pinned, list_result_t result);
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) begin
				@(negedge clk);
				req.valid <= 1'b0;
			end
		pinned_q.push_back('{pinned, result});
		@(negedge clk);
		req.valid <= 1'b1;
		req.op <= op;
		req.value <= value;
		req.position <= position;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic op_t pick_op(int w_ins, int w_del, int w_end, int w_disp, int w_clr);
		int roll;
		roll = $urandom_range(0, w_ins + w_del + w_end + w_disp + w_clr - 1);
		if (roll < w_ins)
			return OP_INSERT;
		roll -= w_ins;
		if (roll < w_del)
			return OP_DELETE;
		roll -= w_del;
		if (roll < w_end)
			return OP_DELETE_END;
		roll -= w_end;
		if (roll < w_disp)
			return OP_DISPLAY;
		return OP_CLEAR;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 9) < 7)
			return POS_W'($urandom_range(0, held + 2));
		return POS_W'($urandom_range(0, 255));
	endfunction

	task automatic run_phase(int count, int w_ins, int w_del, int w_end, int w_disp,
		int w_clr);
		op_t op;
		repeat (count) begin
			op = pick_op(w_ins, w_del, w_end, w_disp, w_clr);
			offer_request(op, pick_value(), pick_position(), 1'b0, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.op <= OP_INSERT;
		req.value <= '0;
		req.position <= '0;
		held = 0;
		error_count = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[s])
			for (int k = 0; k < directed_steps[s].repeats; k++)
				offer_request(directed_steps[s].op, directed_steps[s].value + k,
					directed_steps[s].position, directed_steps[s].pinned,
					directed_steps[s].result);

		run_phase(60, 75, 10, 5, 10, 0);
		// The sender stops until every outstanding result has been returned.
		drain_results();
		hold_off_req = 1'b1;
		run_phase(110, 40, 25, 10, 20, 5);
		run_phase(60, 15, 45, 25, 10, 5);
		run_phase(100, 45, 25, 10, 15, 5);
		calm = 1'b1;
		run_phase(80, 40, 25, 10, 20, 5);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("positional_list_insert_delete_top regression: pass");
		else
			$display("positional_list_insert_delete_top regression: fail");
		$finish;
	end
endmodule

### sim.f
+incdir+sv
sv/plist_pkg.sv
sv/plist_if.sv
sv/plist_cell.sv
sv/positional_list_insert_delete_top.sv
bench/positional_list_insert_delete_top_test.sv
